>>> rtl/sbsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_pkg
// Shared codes, constants and types of the serial bank switch mapper.
// ----------------------------------------------------------------------------
package sbsm_pkg;

    // access kinds
    localparam logic [2:0] OP_CPU_RD = 3'd0;
    localparam logic [2:0] OP_CPU_WR = 3'd1;
    localparam logic [2:0] OP_PPU_RD = 3'd2;
    localparam logic [2:0] OP_PPU_WR = 3'd3;
    localparam logic [2:0] OP_NT     = 3'd4;

    // result targets
    localparam logic [2:0] TGT_NONE      = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM   = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM   = 3'd2;
    localparam logic [2:0] TGT_CHR_ROM   = 3'd3;
    localparam logic [2:0] TGT_CHR_RAM   = 3'd4;
    localparam logic [2:0] TGT_NAMETABLE = 3'd5;

    // configuration register indexes
    localparam logic CFG_PRG_BANK_COUNT = 1'b0;
    localparam logic CFG_CHR_IS_ROM     = 1'b1;

    // mapper register select, address bits 14 to 13
    localparam logic [1:0] SEL_CONTROL  = 2'd0;
    localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
    localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
    localparam logic [1:0] SEL_PRG      = 2'd3;

    // prg modes, control bits 3 to 2
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

    // mirroring modes, control bits 1 to 0
    localparam logic [1:0] MIR_LOW   = 2'd0;
    localparam logic [1:0] MIR_HIGH  = 2'd1;
    localparam logic [1:0] MIR_VERT  = 2'd2;

    localparam logic [4:0]  MAX_PRG_BANKS   = 5'd16;
    localparam logic [4:0]  CTRL_RESET      = 5'h0C;
    localparam logic [4:0]  CTRL_PRG_MODE   = 5'h0C;
    localparam logic [2:0]  SERIAL_LENGTH   = 3'd5;
    localparam logic [4:0]  PRG_BANK_COUNT_RESET = 5'd16;

    localparam logic [15:0] PRG_RAM_BASE  = 16'h6000;
    localparam logic [15:0] PRG_ROM_BASE  = 16'h8000;
    localparam logic [15:0] PRG_UPPER     = 16'hC000;
    localparam logic [15:0] PPU_LIMIT     = 16'h1FFF;
    localparam logic [15:0] CHR_HALF      = 16'h1000;
    localparam logic [15:0] NT_MASK_VERT  = 16'h07FF;
    localparam logic [15:0] NT_MASK_HORZ  = 16'h0BFF;
    localparam logic [15:0] NT_MASK_ONE   = 16'h03FF;
    localparam logic [15:0] NT_PAGE_HIGH  = 16'h0400;

    typedef struct packed {
        logic [4:0] control;
        logic [4:0] chr_low;
        logic [4:0] chr_high;
        logic [4:0] prg;
    } bank_regs_t;

endpackage

>>> rtl/sbsm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_regs
// Serial load register and the four mapper registers it commits to.
// ----------------------------------------------------------------------------
module sbsm_regs
    import sbsm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load_en,
    input  logic [1:0] reg_sel,
    input  logic [7:0] data,
    output bank_regs_t banks
);

    logic [4:0] shift_reg, shift_next;
    logic [2:0] count_reg, count_next;
    bank_regs_t banks_reg, banks_next;

    always_comb begin
        shift_next = shift_reg;
        count_next = count_reg;
        banks_next = banks_reg;
        if (load_en) begin
            if (data[7]) begin
                shift_next = '0;
                count_next = '0;
                banks_next.control = banks_reg.control | CTRL_PRG_MODE;
            end else begin
                shift_next = {data[0], shift_reg[4:1]};
                count_next = count_reg + 3'd1;
                if (count_next >= SERIAL_LENGTH) begin
                    unique case (reg_sel)
                        SEL_CONTROL:  banks_next.control  = shift_next;
                        SEL_CHR_LOW:  banks_next.chr_low  = shift_next;
                        SEL_CHR_HIGH: banks_next.chr_high = shift_next;
                        SEL_PRG:      banks_next.prg      = shift_next;
                        default:      banks_next.prg      = shift_next;
                    endcase
                    shift_next = '0;
                    count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg          <= '0;
            count_reg          <= '0;
            banks_reg.control  <= CTRL_RESET;
            banks_reg.chr_low  <= '0;
            banks_reg.chr_high <= '0;
            banks_reg.prg      <= '0;
        end else begin
            shift_reg <= shift_next;
            count_reg <= count_next;
            banks_reg <= banks_next;
        end
    end

    assign banks = banks_reg;

endmodule

>>> rtl/sbsm_xlate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsm_xlate
// Address translation of one bus access against the mapper registers.
// ----------------------------------------------------------------------------
module sbsm_xlate
    import sbsm_pkg::*;
(
    input  logic [2:0]  op,
    input  logic [15:0] addr,
    input  logic [4:0]  prg_bank_count,
    input  logic        chr_is_rom,
    input  bank_regs_t  banks,
    output logic [2:0]  target,
    output logic [17:0] phys_offset,
    output logic        write_enable,
    output logic        error,
    output logic        serial_wr
);

    logic [4:0]  limit;
    logic [3:0]  prg_p;
    logic [3:0]  prg_bank;
    logic        upper;
    logic [16:0] chr_off;
    logic [4:0]  chr_bank4k;
    logic [15:0] nt_off;

    always_comb begin
        if (prg_bank_count == 5'd0) begin
            limit = 5'd1;
        end else if (prg_bank_count > MAX_PRG_BANKS) begin
            limit = MAX_PRG_BANKS;
        end else begin
            limit = prg_bank_count;
        end
    end

    assign prg_p = banks.prg[3:0];
    assign upper = addr >= PRG_UPPER;

    always_comb begin
        case (banks.control[3:2])
            PRG_MODE_FIX_FIRST: prg_bank = upper ? prg_p : 4'd0;
            PRG_MODE_FIX_LAST:  prg_bank = upper ? 4'(limit - 5'd1) : prg_p;
            default:            prg_bank = upper ? {prg_p[3:1], 1'b1} : {prg_p[3:1], 1'b0};
        endcase
    end

    // 4KB mode when control bit 4 is set
    assign chr_bank4k = (addr >= CHR_HALF) ? banks.chr_high : banks.chr_low;
    assign chr_off = banks.control[4] ? {chr_bank4k, addr[11:0]}
                                      : {banks.chr_low[4:1], addr[12:0]};

    always_comb begin
        case (banks.control[1:0])
            MIR_LOW:  nt_off = addr & NT_MASK_ONE;
            MIR_HIGH: nt_off = (addr & NT_MASK_ONE) | NT_PAGE_HIGH;
            MIR_VERT: nt_off = addr & NT_MASK_VERT;
            default:  nt_off = addr & NT_MASK_HORZ;
        endcase
    end

    always_comb begin
        target       = TGT_NONE;
        phys_offset  = '0;
        write_enable = 1'b0;
        error        = 1'b0;
        serial_wr    = 1'b0;
        case (op)
            OP_CPU_RD, OP_CPU_WR: begin
                if (addr < PRG_RAM_BASE) begin
                    error = 1'b1;
                end else if (addr < PRG_ROM_BASE) begin
                    // prg ram is switched off by prg register bit 4
                    if (!banks.prg[4]) begin
                        target       = TGT_PRG_RAM;
                        phys_offset  = {5'd0, addr[12:0]};
                        write_enable = (op == OP_CPU_WR);
                    end
                end else if (op == OP_CPU_WR) begin
                    serial_wr = 1'b1;
                end else if ({1'b0, prg_bank} >= limit) begin
                    error = 1'b1;
                end else begin
                    target      = TGT_PRG_ROM;
                    phys_offset = {prg_bank, addr[13:0]};
                end
            end
            OP_PPU_RD: begin
                if (addr > PPU_LIMIT) begin
                    error = 1'b1;
                end else begin
                    target      = chr_is_rom ? TGT_CHR_ROM : TGT_CHR_RAM;
                    phys_offset = {1'b0, chr_off};
                end
            end
            OP_PPU_WR: begin
                if (addr > PPU_LIMIT || chr_is_rom) begin
                    error = 1'b1;
                end else begin
                    target       = TGT_CHR_RAM;
                    phys_offset  = {1'b0, chr_off};
                    write_enable = 1'b1;
                end
            end
            OP_NT: begin
                target      = TGT_NAMETABLE;
                phys_offset = {2'd0, nt_off};
            end
            default: begin
                error = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/serial_bank_switch_mapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_unit
// Bank switching mapper: translates bus accesses and takes serial register
// writes.
// ----------------------------------------------------------------------------
// One access enters per clock while the result port is not stalled. Its answer
// passes through the input register, then is translated into the result
// register and presented on the result port, so a steady stream with no
// back-pressure runs at one transaction per cycle. Serial register writes take
// effect for the very next access. The result register lets a new access
// enter while an answer waits to be taken. The configuration port is always
// ready; write it only while no access is in flight.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_unit
    import sbsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // access input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // bus_addr[15:0], write_data[23:16]
    input  logic [2:0]  s_tuser,   // op[2:0]
    // translated result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // phys_offset[17:0], write_enable[18], error[19], zero
    output logic [2:0]  m_tuser,   // target[2:0]
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);

    logic        in_valid_reg;
    logic [2:0]  in_op_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_data_reg;

    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic [2:0]  out_user_reg;

    logic [4:0]  prg_bank_count_reg;
    logic        chr_is_rom_reg;

    logic        advance;
    bank_regs_t  banks;
    logic [2:0]  xl_target;
    logic [17:0] xl_offset;
    logic        xl_we;
    logic        xl_err;
    logic        xl_serial_wr;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_addr_reg <= s_tdata[15:0];
            in_data_reg <= s_tdata[23:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_bank_count_reg <= PRG_BANK_COUNT_RESET;
            chr_is_rom_reg     <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PRG_BANK_COUNT: prg_bank_count_reg <= cfg_data;
                CFG_CHR_IS_ROM:     chr_is_rom_reg     <= cfg_data[0];
                default:            chr_is_rom_reg     <= cfg_data[0];
            endcase
        end
    end

    sbsm_xlate u_xlate (
        .op             (in_op_reg),
        .addr           (in_addr_reg),
        .prg_bank_count (prg_bank_count_reg),
        .chr_is_rom     (chr_is_rom_reg),
        .banks          (banks),
        .target         (xl_target),
        .phys_offset    (xl_offset),
        .write_enable   (xl_we),
        .error          (xl_err),
        .serial_wr      (xl_serial_wr)
    );

    // serial register only moves when the access actually leaves the input stage
    sbsm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load_en (advance && xl_serial_wr),
        .reg_sel (in_addr_reg[14:13]),
        .data    (in_data_reg),
        .banks   (banks)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {4'd0, xl_err, xl_we, xl_offset};
            out_user_reg <= xl_target;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    property p_error_no_target;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[19]) |-> (m_tuser == TGT_NONE);
    endproperty
    a_error_no_target: assert property (p_error_no_target)
        else $error("error result carries a target");

    property p_none_zero_offset;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == TGT_NONE) |-> (m_tdata[18:0] == 19'd0);
    endproperty
    a_none_zero_offset: assert property (p_none_zero_offset)
        else $error("untargeted result with offset or write enable");

    property p_we_target;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[18]) |->
            (m_tuser == TGT_PRG_RAM || m_tuser == TGT_CHR_RAM);
    endproperty
    a_we_target: assert property (p_we_target)
        else $error("write enable on a read-only target");

    property p_stall_cause;
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready);
    endproperty
    a_stall_cause: assert property (p_stall_cause)
        else $error("input stalled with room in the pipeline");

endmodule

>>> tb/serial_bank_switch_mapper_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_unit_tb
// Self-checking bench for the bank switching mapper. Directed accesses probe
// the address boundaries, every access kind and the serial register path.
// Random traffic follows under a range of bank count and pattern memory
// settings, with random idling on both streams and one long output stall.
// A local translation model predicts each answer when its access transaction
// is taken, and every result transaction is checked against the oldest entry.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_unit_tb;
    import sbsm_pkg::*;

    localparam int        TIMEOUT_NS    = 5_000_000;
    localparam int        SETTLE_CYCLES = 6;
    localparam int        STALL_CYCLES  = 80;
    localparam int        ITEMS_PER_SETTING = 60;
    localparam logic [7:0] SERIAL_RESET = 8'h80;

    // bank count and pattern memory kind for each traffic setting
    localparam logic [4:0] BANK_COUNTS [12] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd15,
                                                5'd8, 5'd3, 5'd17, 5'd5, 5'd12, 5'd16};
    localparam logic       CHR_ROM_SETTING [12] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                                                    1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    typedef struct packed {
        logic [2:0]  target;
        logic [17:0] offset;
        logic        we;
        logic        err;
    } xlat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;    // bus_addr[15:0], write_data[23:16]
    logic [2:0]  s_tuser   = '0;    // op[2:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;           // phys_offset[17:0], write_enable[18], error[19], zero
    logic [2:0]  m_tuser;           // target[2:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [4:0]  cfg_data  = '0;

    // mapper state as the bench sees it
    logic [4:0] ser_shift;
    logic [2:0] ser_count;
    logic [4:0] map_control;
    logic [4:0] map_chr_low;
    logic [4:0] map_chr_high;
    logic [4:0] map_prg;
    logic [4:0] cfg_bank_count;
    logic       cfg_chr_rom;

    xlat_t expected_xlat[$];
    int    mismatch_count = 0;
    int    send_idle_pct  = 0;
    int    recv_idle_pct  = 0;
    bit    stall_request  = 1'b0;

    serial_bank_switch_mapper_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [4:0] prg_bank_limit();
        if (cfg_bank_count == 5'd0) return 5'd1;
        if (cfg_bank_count > MAX_PRG_BANKS) return MAX_PRG_BANKS;
        return cfg_bank_count;
    endfunction

    function automatic logic [17:0] chr_offset(input logic [15:0] addr);
        if (map_control[4]) begin
            return {1'b0, ((addr >= CHR_HALF) ? map_chr_high : map_chr_low), addr[11:0]};
        end
        return {1'b0, map_chr_low[4:1], addr[12:0]};
    endfunction

    // answer to one access; cpu writes to the rom window advance the serial port
    function automatic xlat_t translate_access(input logic [2:0] op, input logic [15:0] addr,
                                               input logic [7:0] data);
        xlat_t      r;
        logic [4:0] bank;
        logic [3:0] p;
        logic       upper;
        r = '{target: TGT_NONE, offset: '0, we: 1'b0, err: 1'b0};
        case (op)
            OP_CPU_RD, OP_CPU_WR: begin
                if (addr < PRG_RAM_BASE) begin
                    r.err = 1'b1;
                end else if (addr < PRG_ROM_BASE) begin
                    // prg bit 4 switches work ram off, silently
                    if (!map_prg[4]) begin
                        r.target = TGT_PRG_RAM;
                        r.offset = {5'd0, addr[12:0]};
                        r.we     = (op == OP_CPU_WR);
                    end
                end else if (op == OP_CPU_WR) begin
                    if (data[7]) begin
                        ser_shift   = '0;
                        ser_count   = '0;
                        map_control = map_control | CTRL_PRG_MODE;
                    end else begin
                        ser_shift = {data[0], ser_shift[4:1]};
                        ser_count = ser_count + 3'd1;
                        if (ser_count >= SERIAL_LENGTH) begin
                            case (addr[14:13])
                                SEL_CONTROL:  map_control  = ser_shift;
                                SEL_CHR_LOW:  map_chr_low  = ser_shift;
                                SEL_CHR_HIGH: map_chr_high = ser_shift;
                                default:      map_prg      = ser_shift;
                            endcase
                            ser_shift = '0;
                            ser_count = '0;
                        end
                    end
                end else begin
                    p     = map_prg[3:0];
                    upper = (addr >= PRG_UPPER);
                    case (map_control[3:2])
                        PRG_MODE_FIX_FIRST: bank = upper ? {1'b0, p} : 5'd0;
                        PRG_MODE_FIX_LAST:  bank = upper ? prg_bank_limit() - 5'd1 : {1'b0, p};
                        default:            bank = {1'b0, p[3:1], upper};
                    endcase
                    if (bank >= prg_bank_limit()) begin
                        r.err = 1'b1;
                    end else begin
                        r.target = TGT_PRG_ROM;
                        r.offset = {bank[3:0], addr[13:0]};
                    end
                end
            end
            OP_PPU_RD: begin
                if (addr > PPU_LIMIT) begin
                    r.err = 1'b1;
                end else begin
                    r.target = cfg_chr_rom ? TGT_CHR_ROM : TGT_CHR_RAM;
                    r.offset = chr_offset(addr);
                end
            end
            OP_PPU_WR: begin
                if (addr > PPU_LIMIT || cfg_chr_rom) begin
                    r.err = 1'b1;
                end else begin
                    r.target = TGT_CHR_RAM;
                    r.offset = chr_offset(addr);
                    r.we     = 1'b1;
                end
            end
            OP_NT: begin
                r.target = TGT_NAMETABLE;
                case (map_control[1:0])
                    MIR_LOW:  r.offset = 18'(addr & NT_MASK_ONE);
                    MIR_HIGH: r.offset = 18'((addr & NT_MASK_ONE) | NT_PAGE_HIGH);
                    MIR_VERT: r.offset = 18'(addr & NT_MASK_VERT);
                    default:  r.offset = 18'(addr & NT_MASK_HORZ);
                endcase
            end
            default: begin
                r.err = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // valid stays high across back-to-back transactions; a gap lowers it first
    task automatic send_access(input logic [2:0] op, input logic [15:0] addr,
                               input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {data, addr};
        do @(posedge aclk); while (!s_tready);
        expected_xlat.push_back(translate_access(op, addr, data));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_xlat.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic idx, input logic [4:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PRG_BANK_COUNT) begin
            cfg_bank_count = value;
        end else begin
            cfg_chr_rom = value[0];
        end
    endtask

    // five serial writes; only the last address picks the register
    task automatic serial_commit(input logic [1:0] sel, input logic [4:0] value);
        for (int i = 0; i < 5; i++) begin
            send_access(OP_CPU_WR, {1'b1, (i == 4) ? sel : 2'($urandom), 13'($urandom)},
                        {1'b0, 6'($urandom), value[i]});
        end
    endtask

    task automatic test_directed_edges();
        send_access(OP_CPU_RD, 16'h0000, 8'h00);
        send_access(OP_CPU_WR, PRG_RAM_BASE - 16'd1, 8'hFF);
        send_access(OP_CPU_RD, PRG_RAM_BASE, 8'h00);
        send_access(OP_CPU_WR, PRG_ROM_BASE - 16'd1, 8'hFF);
        send_access(OP_CPU_RD, PRG_ROM_BASE, 8'h00);
        send_access(OP_CPU_RD, PRG_UPPER - 16'd1, 8'h00);
        send_access(OP_CPU_RD, PRG_UPPER, 8'h00);
        send_access(OP_CPU_RD, 16'hFFFF, 8'hFF);
        send_access(OP_PPU_RD, 16'h0000, 8'h00);
        send_access(OP_PPU_RD, PPU_LIMIT, 8'h00);
        send_access(OP_PPU_RD, PPU_LIMIT + 16'd1, 8'h00);
        // write to pattern rom
        send_access(OP_PPU_WR, CHR_HALF - 16'd1, 8'h5A);
        send_access(OP_PPU_WR, 16'hFFFF, 8'hFF);
        send_access(OP_NT, 16'h0000, 8'h00);
        send_access(OP_NT, 16'hFFFF, 8'hFF);
        // unused access kinds
        for (int op = 5; op < 8; op++) begin
            send_access(3'(op), 16'hFFFF, 8'hFF);
        end
        send_access(OP_CPU_WR, PRG_ROM_BASE, SERIAL_RESET);
        // bank 15 with work ram disabled
        serial_commit(SEL_PRG, 5'h1F);
        send_access(OP_CPU_RD, PRG_RAM_BASE, 8'h00);
        send_access(OP_CPU_WR, PRG_ROM_BASE - 16'd1, 8'hA5);
        send_access(OP_CPU_RD, PRG_ROM_BASE, 8'h00);
    endtask

    task automatic test_banked_traffic(input int snd_pct, input int rcv_pct,
                                       input int first_setting);
        int n;
        int pick;
        int sent;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int k = first_setting; k < first_setting + 4; k++) begin
            write_config(CFG_PRG_BANK_COUNT, BANK_COUNTS[k]);
            write_config(CFG_CHR_IS_ROM, {4'd0, CHR_ROM_SETTING[k]});
            n = 0;
            while (n < ITEMS_PER_SETTING) begin
                pick = $urandom_range(99);
                sent = 1;
                if (pick < 25) begin
                    sent = 5;
                    if ($urandom_range(3) == 0) begin
                        send_access(OP_CPU_WR, PRG_ROM_BASE | 16'($urandom),
                                    SERIAL_RESET | 8'($urandom));
                        sent = 6;
                    end
                    serial_commit(2'($urandom), 5'($urandom));
                end else if (pick < 30) begin
                    // reset dropped into the middle of a sequence
                    send_access(OP_CPU_WR, PRG_ROM_BASE | 16'($urandom),
                                SERIAL_RESET | 8'($urandom));
                end else if (pick < 38) begin
                    send_access(OP_CPU_WR, PRG_ROM_BASE | 16'($urandom),
                                8'($urandom) & ~SERIAL_RESET);
                end else if (pick < 58) begin
                    send_access(OP_CPU_RD, 16'($urandom_range(16'hFFFF, PRG_RAM_BASE)),
                                8'($urandom));
                end else if (pick < 64) begin
                    send_access($urandom_range(1) ? OP_CPU_WR : OP_CPU_RD,
                                16'($urandom_range(PRG_ROM_BASE - 16'd1, PRG_RAM_BASE)),
                                8'($urandom));
                end else if (pick < 80) begin
                    send_access($urandom_range(1) ? OP_PPU_WR : OP_PPU_RD,
                                16'($urandom_range(PPU_LIMIT, 0)), 8'($urandom));
                end else if (pick < 88) begin
                    send_access(OP_NT, 16'($urandom), 8'($urandom));
                end else if (pick < 94) begin
                    send_access(3'($urandom), 16'($urandom), 8'($urandom));
                end else begin
                    send_access(3'($urandom_range(3)), 16'($urandom), 8'($urandom));
                end
                n += sent;
            end
        end
    endtask

    // receiver holds off long enough for the block to back up into its input
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 1'b1;
        repeat (24) begin
            if ($urandom_range(1)) begin
                send_access(OP_CPU_RD, 16'($urandom_range(16'hFFFF, PRG_RAM_BASE)),
                            8'($urandom));
            end else begin
                send_access(OP_NT, 16'($urandom), 8'($urandom));
            end
        end
    endtask

    always @(posedge aclk) begin : result_ready
        int stall_left;
        if (stall_request) begin
            stall_left    = STALL_CYCLES;
            stall_request = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        xlat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_xlat.size() == 0) begin
                report_mismatch("transaction with nothing expected, tdata", 0, m_tdata);
            end else begin
                want = expected_xlat.pop_front();
                if (m_tuser != want.target) report_mismatch("target", want.target, m_tuser);
                if (m_tdata[17:0] != want.offset) begin
                    report_mismatch("phys_offset", want.offset, m_tdata[17:0]);
                end
                if (m_tdata[18] != want.we) report_mismatch("write_enable", want.we, m_tdata[18]);
                if (m_tdata[19] != want.err) report_mismatch("error", want.err, m_tdata[19]);
            end
        end
    end

    initial begin
        ser_shift      = '0;
        ser_count      = '0;
        map_control    = CTRL_RESET;
        map_chr_low    = '0;
        map_chr_high   = '0;
        map_prg        = '0;
        cfg_bank_count = PRG_BANK_COUNT_RESET;
        cfg_chr_rom    = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 31;
        recv_idle_pct = 66;
        test_directed_edges();
        test_banked_traffic(31, 66, 0);
        test_output_stall();
        test_banked_traffic(66, 31, 4);
        test_banked_traffic(0, 0, 8);
        wait_idle();
        if (mismatch_count == 0) begin
            $display("serial_bank_switch_mapper_unit verification clean");
        end else begin
            $display("serial_bank_switch_mapper_unit verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("serial_bank_switch_mapper_unit verification failed");
        $finish;
    end

endmodule
